// ===== rtl/core/radix_digit_string_converter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Radix digit string converter: assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_STRING_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_STRING_CONVERTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define RDSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define RDSC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RDSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RDSC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/core/rdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Radix digit string converter: package
// Shared widths, codes and types of the converter core.
// ----------------------------------------------------------------------------
package rdsc_pkg;

  // Default parameter values of the core.
  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned MAX_RADIX_DEF   = 16;
  localparam int unsigned MAX_DIGITS_DEF  = 64;

  // Fixed field widths.
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Smallest usable radix.
  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIX    = 2'd0,
    CFG_CHARS_LO = 2'd1,
    CFG_CHARS_HI = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_e;

  // Link between neighbouring division cells.
  typedef struct packed {
    logic               tok;
    logic [DIGIT_W-1:0] rem;
    logic               nz;
  } rdsc_link_t;

endpackage

// ===== rtl/core/rdsc_if.sv =====
// ----------------------------------------------------------------------------
// Radix digit string converter: stream interfaces
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------
interface rdsc_in_if
  import rdsc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdsc_out_if
  import rdsc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  logic              error;

  modport source (output valid, output digit_char, output last, output error, input ready);
  modport sink   (input valid, input digit_char, input last, input error, output ready);
endinterface

// ===== rtl/core/rdsc_ram.sv =====
// ----------------------------------------------------------------------------
// Radix digit string converter: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdsc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rdsc_cell.sv =====
// ----------------------------------------------------------------------------
// Radix digit string converter: division cell
// Holds one nibble of the running quotient and divides it by the radix,
// taking the partial remainder from its upper neighbour.
// ----------------------------------------------------------------------------
module rdsc_cell
  import rdsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic [DIGIT_W-1:0] load_nib_i,
  input  logic [RADIX_W-1:0] radix_i,
  input  rdsc_link_t         link_i,
  output rdsc_link_t         link_o
);

  logic               tok_q;
  logic [DIGIT_W-1:0] nib_q;
  logic [DIGIT_W-1:0] rem_q;
  logic               nz_q;

  logic [DIGIT_W-1:0] quo_d;
  logic [DIGIT_W-1:0] rem_d;

  // Restoring division of {remainder in, nibble} by the radix, one bit a step.
  // The partial value is one bit wider than a digit, which is the radix width.
  always_comb begin
    logic [DIGIT_W:0]   part;
    logic [DIGIT_W-1:0] rem;
    rem   = link_i.rem;
    quo_d = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      part = {rem, nib_q[i]};
      if (part >= radix_i) begin
        quo_d[i] = 1'b1;
        part     = part - radix_i;
      end
      rem = part[DIGIT_W-1:0];
    end
    rem_d = rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (load_i) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= link_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      nib_q <= load_nib_i;
    end else if (link_i.tok) begin
      nib_q <= quo_d;
      rem_q <= rem_d;
      nz_q  <= link_i.nz | (quo_d != '0);
    end
  end

  assign link_o = '{tok: tok_q, rem: rem_q, nz: nz_q};

endmodule

// ===== rtl/core/radix_digit_string_converter_core.sv =====
// ----------------------------------------------------------------------------
// Radix digit string converter core
// Converts unsigned values into digit characters, most significant first.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake      Beat contents
//  -------  ---------  -------------  ------------------------------------
//  in_ch    sink       valid/ready    value (VALUE_WIDTH bits)
//  out_ch   source     valid/ready    digit_char (8), last, error
//  cfg      write only cfg_we_i       cfg_idx_i selects, cfg_wdata_i data
//
// One value is handled at a time. The division wavefront crosses the row of
// NCELL nibble cells (16 for a 64-bit value) and then yields one digit a
// cycle into the digit RAM, which is then read back at one beat a cycle
// while the output is free.
// Reset is asynchronous and active low and clears the state, the counters,
// the output valid flag and the configuration registers. A stall on the output
// holds the current beat and pauses the RAM read-back; no input is taken until
// the last beat has left.
`include "radix_digit_string_converter_core_macros.svh"

module radix_digit_string_converter_core
  import rdsc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_RADIX   = MAX_RADIX_DEF,
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rdsc_in_if.sink              in_ch,
  rdsc_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Number of nibble cells and the padded value width they cover.
  localparam int unsigned NCELL = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned PAD_W = NCELL * DIGIT_W;
  // Digit RAM address width and digit counter width (holds MAX_DIGITS).
  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned CW    = $clog2(MAX_DIGITS + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RADIX_W-1:0] radix_q;
  logic [CFG_W-1:0]   chars_lo_q;
  logic [CFG_W-1:0]   chars_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= '0;
      chars_lo_q <= '0;
      chars_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIX:    radix_q    <= cfg_wdata_i[RADIX_W-1:0];
        CFG_CHARS_LO: chars_lo_q <= cfg_wdata_i;
        CFG_CHARS_HI: chars_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Looks up the character of a digit in the two table words.
  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d,
                                                input logic [CFG_W-1:0]   lo,
                                                input logic [CFG_W-1:0]   hi);
    logic [CFG_W-1:0] word;
    word = d[DIGIT_W-1] ? hi : lo;
    word = word >> {d[DIGIT_W-2:0], 3'b000};
    return word[CHAR_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Control signals
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [RADIX_W-1:0] r_eff_q;
  logic [CW-1:0]      wr_cnt_q, wr_cnt_d;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic [CW-1:0]      rd_cnt_m1;
  logic               out_valid_q, out_valid_d;
  logic               err_q, err_d;
  logic               last_q, last_d;

  logic               in_ready;
  logic               in_fire;
  logic               radix_ok;
  logic               go;
  logic               dig_fire;
  logic               conv_done;
  logic               out_fire;
  logic               rd_issue;
  logic               emit_done;

  rdsc_link_t         link [NCELL+1];
  rdsc_link_t         tail;
  logic [PAD_W-1:0]   value_pad;
  logic [DIGIT_W-1:0] ram_rdata;

  assign tail      = link[NCELL];
  assign radix_ok  = (radix_q >= MIN_RADIX);
  assign value_pad = PAD_W'(in_ch.value);
  assign rd_cnt_m1 = rd_cnt_q - CW'(1);

  // Handshake and sequencing strobes, decoded from the state.
  always_comb begin
    in_ready  = (state_q == S_IDLE);
    in_fire   = in_ch.valid && in_ready;
    go        = (state_q == S_CONV);
    // The last cell presents one finished division per cycle once the
    // wavefront has crossed the row; its remainder is the next digit.
    dig_fire  = go && tail.tok;
    conv_done = dig_fire && (!tail.nz || (wr_cnt_q == CW'(MAX_DIGITS - 1)));
    out_fire  = out_valid_q && out_ch.ready;
    rd_issue  = (state_q == S_EMIT) && (rd_cnt_q != '0) &&
                (!out_valid_q || out_ch.ready);
    emit_done = (state_q == S_EMIT) && (rd_cnt_q == '0) &&
                (!out_valid_q || out_ch.ready);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = radix_ok ? S_CONV : S_EMIT;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Counters and the output beat register.
  always_comb begin
    wr_cnt_d    = wr_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q;
    err_d       = err_q;
    last_d      = last_q;

    if (in_fire) begin
      wr_cnt_d = '0;
      rd_cnt_d = '0;
      if (!radix_ok) begin
        // A radix below two gives a single flagged beat and no digits.
        out_valid_d = 1'b1;
        err_d       = 1'b1;
        last_d      = 1'b1;
      end
    end

    if (dig_fire) begin
      wr_cnt_d = wr_cnt_q + CW'(1);
    end
    if (conv_done) begin
      rd_cnt_d = wr_cnt_q + CW'(1);
    end

    if (rd_issue) begin
      // Digits were stored least significant first, so read downwards.
      rd_cnt_d    = rd_cnt_m1;
      out_valid_d = 1'b1;
      err_d       = 1'b0;
      last_d      = (rd_cnt_q == CW'(1));
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_cnt_q    <= wr_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    last_q <= last_d;
    if (in_fire) begin
      // Radix values above the supported maximum saturate.
      r_eff_q <= (radix_q > RADIX_W'(MAX_RADIX)) ? RADIX_W'(MAX_RADIX) : radix_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Division cell row
  // ---------------------------------------------------------------------------
  // Cell 0 holds the most significant nibble. Each cell runs division k in the
  // cycle after its upper neighbour, so a new division enters the row every
  // cycle and the quotient never has to ripple across the whole word.
  assign link[0] = '{tok: go, rem: '0, nz: 1'b0};

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rdsc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (in_fire),
      .load_nib_i (value_pad[(NCELL-1-g)*DIGIT_W +: DIGIT_W]),
      .radix_i    (r_eff_q),
      .link_i     (link[g]),
      .link_o     (link[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Digit buffer
  // ---------------------------------------------------------------------------
  rdsc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (dig_fire),
    .waddr_i (wr_cnt_q[AW-1:0]),
    .wdata_i (tail.rem),
    .re_i    (rd_issue),
    .raddr_i (rd_cnt_m1[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_q;
  assign out_ch.digit_char = err_q ? '0 : char_of(ram_rdata, chars_lo_q, chars_hi_q);
  assign out_ch.last       = last_q;
  assign out_ch.error      = err_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RDSC_ASSERT(a_in_only_when_out_empty, clk_i, rst_ni,
               in_fire |-> !out_valid_q, "input taken while a beat is pending")
  `RDSC_ASSERT_NEVER(a_ram_write_outside_conv, clk_i, rst_ni,
                     dig_fire && (state_q != S_CONV), "digit written outside conversion")
  `RDSC_ASSERT(a_err_beat_is_last, clk_i, rst_ni,
               (out_valid_q && err_q) |-> last_q, "error beat without last")
  `RDSC_ASSERT(a_final_read_flags_last, clk_i, rst_ni,
               (rd_issue && (rd_cnt_q == CW'(1))) |=> (out_valid_q && last_q),
               "final digit not flagged last")

endmodule
